>>> hw/rtl/dhmn_pkg.sv
package dhmn_pkg;

   // Field and register widths
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int THR_W           = 10;
   localparam int NOTE_W          = 7;
   localparam int SENS_W          = 4;
   localparam int CAP_W           = 10;
   localparam int LEN_W           = 14;
   localparam int ELAPSED_W       = 8;
   localparam int STATUS_W        = 8;
   localparam int VEL_W           = 7;
   localparam int TIMER_W         = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 14;

   // Velocity gain: (s+2) fits 5 bits, times MAX_VEL (7 bits)
   localparam int FACT_W = 12;
   localparam logic [VEL_W-1:0] MAX_VEL = 7'd127;

   // Register reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RST   = 10'd50;
   localparam logic [NOTE_W-1:0] NOTE_NUMBER_RST = 7'd38;
   localparam logic [SENS_W-1:0] SENSITIVITY_RST = 4'd1;
   localparam logic [CAP_W-1:0]  CAPTURE_RST     = 10'd3;
   localparam logic [LEN_W-1:0]  NOTE_LENGTH_RST = 14'd50;

   // Message status bytes, channel 0
   localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_NUMBER = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSITIVITY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_LENGTH = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COLLECT = 3'd1,
      MODE_ON_DUE  = 3'd2,
      MODE_HOLD    = 3'd3,
      MODE_OFF_DUE = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CTL_READY = 2'd0,
      CTL_MUL   = 2'd1,
      CTL_DIV   = 2'd2
   } ctl_state_type;

   typedef enum logic [1:0] {
      TIMER_HOLD  = 2'd0,
      TIMER_ADD   = 2'd1,
      TIMER_CLEAR = 2'd2
   } timer_op_type;

   typedef enum logic [1:0] {
      PEAK_HOLD  = 2'd0,
      PEAK_MAX   = 2'd1,
      PEAK_CLEAR = 2'd2
   } peak_op_type;

   typedef struct packed {
      timer_op_type timer_op;
      peak_op_type  peak_op;
      logic         vel_prep;
      logic         mul;
      logic         div_step;
      logic         emit_on;
      logic         emit_off;
   } cmd_type;

   typedef struct packed {
      logic sample_above;
      logic cap_reached;
      logic len_reached;
      logic div_last;
      logic out_busy;
   } stat_type;

endpackage

>>> hw/rtl/drum_hit_to_midi_note.sv
// A note-off is shown on rsp_valid the cycle after acceptance. A note-on request runs
// operand preparation, multiply, then SAMPLE_BITS + 12 divide steps before it is shown.
// Throughput: one request per cycle outside note-on while no result waits under rsp_stall;
// the divider bounds the rest.
// Reset: synchronous, active high; clears mode, hit timer, peak, output valid and loads the
// register defaults (threshold 50, note 38, sensitivity 1, capture 3 ms, length 50 ms).
module drum_hit_to_midi_note #(
   parameter int SAMPLE_BITS = dhmn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   input  logic [dhmn_pkg::ELAPSED_W-1:0]   req_elapsed_ms,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dhmn_pkg::STATUS_W-1:0]    rsp_status_byte,
   output logic [dhmn_pkg::NOTE_W-1:0]      rsp_note,
   output logic [dhmn_pkg::VEL_W-1:0]       rsp_velocity,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dhmn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dhmn_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Commands from the sequencer, status back from the datapath
   dhmn_pkg::cmd_type  cmd;
   dhmn_pkg::stat_type st;

   // Sequencer: holds the hit mode (idle, collect peak, note-on due, hold,
   // note-off due) and steps the velocity calculation. Stall requests while
   // the multiply or divider runs, or while a result waits and is being held off.
   dhmn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, saturating hit timer, peak tracker,
   // velocity multiply and divider, and the result register that holds a finished
   // result until it is taken; requests stall while it waits and is held off.
   dhmn_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .req_elapsed_ms  (req_elapsed_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte),
      .rsp_note        (rsp_note),
      .rsp_velocity    (rsp_velocity),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .st              (st)
   );

endmodule

>>> hw/rtl/dhmn_ctrl.sv
module dhmn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dhmn_pkg::stat_type st,
   output dhmn_pkg::cmd_type  cmd
);

   dhmn_pkg::ctl_state_type state_ff, state_in;
   dhmn_pkg::mode_type      mode_ff, mode_in;
   logic                    accept;

   assign req_stall = (state_ff != dhmn_pkg::CTL_READY) || st.out_busy;
   assign accept    = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      case (state_ff)
         dhmn_pkg::CTL_READY: begin
            if (accept) begin
               case (mode_ff)
                  dhmn_pkg::MODE_IDLE: begin
                     if (st.sample_above) mode_in = dhmn_pkg::MODE_COLLECT;
                  end
                  dhmn_pkg::MODE_COLLECT: begin
                     if (st.cap_reached) mode_in = dhmn_pkg::MODE_ON_DUE;
                  end
                  dhmn_pkg::MODE_ON_DUE: begin
                     mode_in  = dhmn_pkg::MODE_HOLD;
                     state_in = dhmn_pkg::CTL_MUL;
                  end
                  dhmn_pkg::MODE_HOLD: begin
                     if (st.len_reached) mode_in = dhmn_pkg::MODE_OFF_DUE;
                  end
                  dhmn_pkg::MODE_OFF_DUE: mode_in = dhmn_pkg::MODE_IDLE;
                  default: mode_in = dhmn_pkg::MODE_IDLE;
               endcase
            end
         end
         dhmn_pkg::CTL_MUL: state_in = dhmn_pkg::CTL_DIV;
         dhmn_pkg::CTL_DIV: begin
            if (st.div_last) state_in = dhmn_pkg::CTL_READY;
         end
         default: state_in = dhmn_pkg::CTL_READY;
      endcase
   end

   // Commands
   always_comb begin
      cmd          = '0;
      cmd.timer_op = dhmn_pkg::TIMER_HOLD;
      cmd.peak_op  = dhmn_pkg::PEAK_HOLD;
      case (state_ff)
         dhmn_pkg::CTL_READY: begin
            if (accept) begin
               case (mode_ff)
                  dhmn_pkg::MODE_IDLE: begin
                     if (st.sample_above) cmd.timer_op = dhmn_pkg::TIMER_CLEAR;
                  end
                  dhmn_pkg::MODE_COLLECT: begin
                     cmd.timer_op = dhmn_pkg::TIMER_ADD;
                     cmd.peak_op  = dhmn_pkg::PEAK_MAX;
                  end
                  dhmn_pkg::MODE_ON_DUE: begin
                     cmd.timer_op = dhmn_pkg::TIMER_ADD;
                     cmd.vel_prep = 1'b1;
                  end
                  dhmn_pkg::MODE_HOLD: cmd.timer_op = dhmn_pkg::TIMER_ADD;
                  dhmn_pkg::MODE_OFF_DUE: begin
                     cmd.timer_op = dhmn_pkg::TIMER_CLEAR;
                     cmd.peak_op  = dhmn_pkg::PEAK_CLEAR;
                     cmd.emit_off = 1'b1;
                  end
                  default: cmd.timer_op = dhmn_pkg::TIMER_HOLD;
               endcase
            end
         end
         dhmn_pkg::CTL_MUL: cmd.mul = 1'b1;
         dhmn_pkg::CTL_DIV: begin
            cmd.div_step = 1'b1;
            cmd.emit_on  = st.div_last;
         end
         default: cmd.mul = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhmn_pkg::CTL_READY;
         mode_ff  <= dhmn_pkg::MODE_IDLE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   a_on_due_starts_calc: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == dhmn_pkg::MODE_ON_DUE)
      |=> (state_ff == dhmn_pkg::CTL_MUL && mode_ff == dhmn_pkg::MODE_HOLD))
      else $error("note-on request did not start the velocity calculation");

   a_calc_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dhmn_pkg::CTL_READY) |-> (mode_ff == dhmn_pkg::MODE_HOLD))
      else $error("velocity calculation running outside hold");

   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dhmn_pkg::CTL_MUL) |=> (state_ff == dhmn_pkg::CTL_DIV))
      else $error("multiply cycle not followed by division");

endmodule

>>> hw/rtl/dhmn_datapath.sv
module dhmn_datapath #(
   parameter int SAMPLE_BITS = dhmn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic [dhmn_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dhmn_pkg::STATUS_W-1:0]       rsp_status_byte,
   output logic [dhmn_pkg::NOTE_W-1:0]         rsp_note,
   output logic [dhmn_pkg::VEL_W-1:0]          rsp_velocity,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dhmn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dhmn_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  dhmn_pkg::cmd_type                   cmd,
   output dhmn_pkg::stat_type                  st
);

   localparam int CMP_W = (SAMPLE_BITS > dhmn_pkg::THR_W) ? SAMPLE_BITS : dhmn_pkg::THR_W;
   localparam int DEN_W = SAMPLE_BITS + 2;
   localparam int NUM_W = dhmn_pkg::FACT_W + SAMPLE_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
   localparam int TW = dhmn_pkg::TIMER_W;

   // Configuration registers
   logic [dhmn_pkg::THR_W-1:0]  thr_ff;
   logic [dhmn_pkg::NOTE_W-1:0] note_ff;
   logic [dhmn_pkg::SENS_W-1:0] sens_ff;
   logic [dhmn_pkg::CAP_W-1:0]  cap_ff;
   logic [dhmn_pkg::LEN_W-1:0]  len_ff;

   // Hit state
   logic [TW-1:0]          timer_ff, timer_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;

   // Velocity divider
   logic [SAMPLE_BITS-1:0]     diff_ff;
   logic [dhmn_pkg::FACT_W-1:0] fact_ff;
   logic [DEN_W-1:0]           den_ff;
   logic [NUM_W-1:0]           num_ff;
   logic [DEN_W-1:0]           rem_ff;
   logic [CNT_W-1:0]           cnt_ff;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dhmn_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [dhmn_pkg::NOTE_W-1:0]   rsp_note_ff;
   logic [dhmn_pkg::VEL_W-1:0]    rsp_vel_ff;

   logic [TW:0]            timer_sum;
   logic [TW-1:0]          timer_sat;
   logic [CMP_W-1:0]       thr_ext;
   logic [SAMPLE_BITS-1:0] thr_s;
   logic                   vel_zero;
   logic [SAMPLE_BITS-1:0] span;
   logic [4:0]             gain;
   logic [DEN_W:0]         rem_shift;
   logic                   q_bit;
   logic [NUM_W-1:0]       quot_next;
   logic [dhmn_pkg::VEL_W-1:0] vel_sat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= dhmn_pkg::THRESHOLD_RST;
         note_ff <= dhmn_pkg::NOTE_NUMBER_RST;
         sens_ff <= dhmn_pkg::SENSITIVITY_RST;
         cap_ff  <= dhmn_pkg::CAPTURE_RST;
         len_ff  <= dhmn_pkg::NOTE_LENGTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            dhmn_pkg::CSR_THRESHOLD:   thr_ff  <= csr_wdata[dhmn_pkg::THR_W-1:0];
            dhmn_pkg::CSR_NOTE_NUMBER: note_ff <= csr_wdata[dhmn_pkg::NOTE_W-1:0];
            dhmn_pkg::CSR_SENSITIVITY: sens_ff <= csr_wdata[dhmn_pkg::SENS_W-1:0];
            dhmn_pkg::CSR_CAPTURE:     cap_ff  <= csr_wdata[dhmn_pkg::CAP_W-1:0];
            dhmn_pkg::CSR_NOTE_LENGTH: len_ff  <= csr_wdata[dhmn_pkg::LEN_W-1:0];
            default: thr_ff <= thr_ff;
         endcase
      end
   end

   // Saturating hit timer
   assign timer_sum = {1'b0, timer_ff} + (TW + 1)'(req_elapsed_ms);
   assign timer_sat = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];

   always_comb begin
      case (cmd.timer_op)
         dhmn_pkg::TIMER_ADD:   timer_in = timer_sat;
         dhmn_pkg::TIMER_CLEAR: timer_in = '0;
         default:               timer_in = timer_ff;
      endcase
      case (cmd.peak_op)
         dhmn_pkg::PEAK_MAX:   peak_in = (req_sample > peak_ff) ? req_sample : peak_ff;
         dhmn_pkg::PEAK_CLEAR: peak_in = '0;
         default:              peak_in = peak_ff;
      endcase
   end

   assign thr_ext = CMP_W'(thr_ff);
   assign thr_s   = thr_ext[SAMPLE_BITS-1:0];

   assign st.sample_above = CMP_W'(req_sample) > thr_ext;
   assign st.cap_reached  = timer_sat >= TW'(cap_ff);
   assign st.len_reached  = timer_sat >= TW'(len_ff);
   assign st.div_last     = cnt_ff == CNT_W'(NUM_W - 1);
   assign st.out_busy     = rsp_valid_ff && rsp_stall;

   // Velocity operands: zero peak excess or full-scale threshold give velocity 0
   assign vel_zero = (CMP_W'(peak_ff) <= thr_ext) || (thr_ext >= CMP_W'(FULL_SCALE));
   assign span     = FULL_SCALE - thr_s;
   assign gain     = 5'(sens_ff) + 5'd2;

   // One restoring division step a cycle
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign q_bit     = rem_shift >= {1'b0, den_ff};
   assign quot_next = {num_ff[NUM_W-2:0], q_bit};
   assign vel_sat   = (quot_next > NUM_W'(dhmn_pkg::MAX_VEL)) ? dhmn_pkg::MAX_VEL
                                                             : quot_next[dhmn_pkg::VEL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.vel_prep) begin
         diff_ff <= vel_zero ? '0 : (peak_ff - thr_s);
         den_ff  <= vel_zero ? DEN_W'(1) : (DEN_W'({span, 1'b0}) + DEN_W'(span));
         fact_ff <= dhmn_pkg::FACT_W'(gain) * dhmn_pkg::FACT_W'(dhmn_pkg::MAX_VEL);
      end
      if (cmd.mul) begin
         num_ff <= NUM_W'(fact_ff) * NUM_W'(diff_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= quot_next;
         rem_ff <= q_bit ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mul) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_on || cmd.emit_off) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_on) begin
         rsp_status_ff <= dhmn_pkg::STATUS_NOTE_ON;
         rsp_note_ff   <= note_ff;
         rsp_vel_ff    <= vel_sat;
      end else if (cmd.emit_off) begin
         rsp_status_ff <= dhmn_pkg::STATUS_NOTE_OFF;
         rsp_note_ff   <= note_ff;
         rsp_vel_ff    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timer_ff     <= timer_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = rsp_status_ff;
   assign rsp_note        = rsp_note_ff;
   assign rsp_velocity    = rsp_vel_ff;

   a_note_on_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_on |-> !rsp_valid_ff)
      else $error("note-on written over a pending result");

   a_note_off_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == dhmn_pkg::STATUS_NOTE_OFF) |-> (rsp_vel_ff == '0))
      else $error("note-off with non-zero velocity");

   a_timer_monotonic: assert property (@(posedge clock) disable iff (reset)
      (cmd.timer_op == dhmn_pkg::TIMER_ADD) |=> (timer_ff >= $past(timer_ff)))
      else $error("hit timer wrapped instead of saturating");

endmodule

>>> tb/drum_hit_to_midi_note_test.sv
module drum_hit_to_midi_note_test;

   localparam int SMP_W           = dhmn_pkg::SAMPLE_BITS_DEF;
   localparam int FULL_SCALE      = (1 << SMP_W) - 1;
   localparam int RESET_CYCLES    = 10;
   // Longest request is a note-on, through multiply and divide; give it ample room.
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_REPORTS     = 10;
   localparam int ITEMS_PER_PHASE = 66;
   localparam int NUM_PHASES      = 6;

   // Register setting kinds used by the random phases
   localparam int SET_TYPICAL  = 0;
   localparam int SET_LOW_EDGE = 1;
   localparam int SET_HIGH_END = 2;
   localparam int SET_BEYOND   = 3;

   // Indexes outside the register map; writes there must leave everything alone
   localparam logic [dhmn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [dhmn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [dhmn_pkg::STATUS_W-1:0] status_byte;
      logic [dhmn_pkg::NOTE_W-1:0]   note;
      logic [dhmn_pkg::VEL_W-1:0]    velocity;
   } note_msg_type;

   // Tracks the pad state machine and the MIDI messages it owes.
   class midi_message_tracker;
      logic [dhmn_pkg::THR_W-1:0]   threshold;
      logic [dhmn_pkg::NOTE_W-1:0]  note_number;
      logic [dhmn_pkg::SENS_W-1:0]  sensitivity;
      logic [dhmn_pkg::CAP_W-1:0]   capture_ms;
      logic [dhmn_pkg::LEN_W-1:0]   note_length_ms;
      dhmn_pkg::mode_type           mode;
      logic [dhmn_pkg::TIMER_W-1:0] hit_timer;
      logic [SMP_W-1:0]             peak;
      note_msg_type                 due_msgs[$];
      int                           failures;

      function new();
         threshold      = dhmn_pkg::THRESHOLD_RST;
         note_number    = dhmn_pkg::NOTE_NUMBER_RST;
         sensitivity    = dhmn_pkg::SENSITIVITY_RST;
         capture_ms     = dhmn_pkg::CAPTURE_RST;
         note_length_ms = dhmn_pkg::NOTE_LENGTH_RST;
         mode           = dhmn_pkg::MODE_IDLE;
         hit_timer      = '0;
         peak           = '0;
         failures       = 0;
      endfunction

      function int pending();
         return due_msgs.size();
      endfunction

      function void write_register(logic [dhmn_pkg::CSR_INDEX_W-1:0] idx,
                                  logic [dhmn_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            dhmn_pkg::CSR_THRESHOLD:   threshold      = data[dhmn_pkg::THR_W-1:0];
            dhmn_pkg::CSR_NOTE_NUMBER: note_number    = data[dhmn_pkg::NOTE_W-1:0];
            dhmn_pkg::CSR_SENSITIVITY: sensitivity    = data[dhmn_pkg::SENS_W-1:0];
            dhmn_pkg::CSR_CAPTURE:     capture_ms     = data[dhmn_pkg::CAP_W-1:0];
            dhmn_pkg::CSR_NOTE_LENGTH: note_length_ms = data[dhmn_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Linear curve, floored, saturated at the top velocity
      function logic [dhmn_pkg::VEL_W-1:0] velocity_for(logic [SMP_W-1:0] pk);
         longint unsigned num;
         longint unsigned den;
         longint unsigned v;
         if (pk <= threshold || threshold >= FULL_SCALE) return '0;
         num = (64'(sensitivity) + 2) * 64'(dhmn_pkg::MAX_VEL) * (64'(pk) - 64'(threshold));
         den = 3 * (64'(FULL_SCALE) - 64'(threshold));
         v = num / den;
         if (v > 64'(dhmn_pkg::MAX_VEL)) v = 64'(dhmn_pkg::MAX_VEL);
         return v[dhmn_pkg::VEL_W-1:0];
      endfunction

      function void note_request(logic [SMP_W-1:0] smp, logic [dhmn_pkg::ELAPSED_W-1:0] el);
         logic [dhmn_pkg::TIMER_W:0] sum;
         if (mode != dhmn_pkg::MODE_IDLE) begin
            sum = {1'b0, hit_timer} + el;
            hit_timer = sum[dhmn_pkg::TIMER_W] ? '1 : sum[dhmn_pkg::TIMER_W-1:0];
         end
         case (mode)
            dhmn_pkg::MODE_IDLE: begin
               if (smp > threshold) begin
                  hit_timer = '0;
                  mode = dhmn_pkg::MODE_COLLECT;
               end
            end
            dhmn_pkg::MODE_COLLECT: begin
               if (smp > peak) peak = smp;
               if (hit_timer >= capture_ms) mode = dhmn_pkg::MODE_ON_DUE;
            end
            dhmn_pkg::MODE_ON_DUE: begin
               due_msgs.push_back('{dhmn_pkg::STATUS_NOTE_ON, note_number,
                                    velocity_for(peak)});
               mode = dhmn_pkg::MODE_HOLD;
            end
            dhmn_pkg::MODE_HOLD: begin
               if (hit_timer >= note_length_ms) mode = dhmn_pkg::MODE_OFF_DUE;
            end
            dhmn_pkg::MODE_OFF_DUE: begin
               due_msgs.push_back('{dhmn_pkg::STATUS_NOTE_OFF, note_number, '0});
               hit_timer = '0;
               peak = '0;
               mode = dhmn_pkg::MODE_IDLE;
            end
            default: mode = dhmn_pkg::MODE_IDLE;
         endcase
      endfunction

      function void check_message(logic [dhmn_pkg::STATUS_W-1:0] st,
                                  logic [dhmn_pkg::NOTE_W-1:0] nt,
                                  logic [dhmn_pkg::VEL_W-1:0] vel);
         note_msg_type want;
         if (due_msgs.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected message: status %h note %0d velocity %0d", st, nt, vel);
            return;
         end
         want = due_msgs.pop_front();
         if (want.status_byte !== st || want.note !== nt || want.velocity !== vel) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("message mismatch: expected %h %0d %0d, got %h %0d %0d",
                        want.status_byte, want.note, want.velocity, st, nt, vel);
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_stall;
   logic [SMP_W-1:0]                 req_sample     = '0;
   logic [dhmn_pkg::ELAPSED_W-1:0]   req_elapsed_ms = '0;
   logic                             rsp_valid;
   logic                             rsp_stall      = 1'b0;
   logic [dhmn_pkg::STATUS_W-1:0]    rsp_status_byte;
   logic [dhmn_pkg::NOTE_W-1:0]      rsp_note;
   logic [dhmn_pkg::VEL_W-1:0]       rsp_velocity;
   logic                             csr_valid      = 1'b0;
   logic                             csr_ready;
   logic [dhmn_pkg::CSR_INDEX_W-1:0] csr_index      = '0;
   logic [dhmn_pkg::CSR_DATA_W-1:0]  csr_wdata      = '0;

   midi_message_tracker tracker;

   // Idle percentages for each side; the sequence below changes them per regime
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // A request for a long receiver hold-off is counted here and served by the receiver
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int hold_off_left     = 0;
   int quiet_cycles      = 0;

   drum_hit_to_midi_note DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_elapsed_ms  (req_elapsed_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte),
      .rsp_note        (rsp_note),
      .rsp_velocity    (rsp_velocity),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stall at random, or hold off for a long stretch when asked so that
   // the block fills and pushes back on the request side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Check every accepted message against the oldest one owed. Values seen here
   // are the ones from before the edge, so ordering against the drivers is moot.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_message(rsp_status_byte, rsp_note, rsp_velocity);
   end

   // Watchdog: end the run if nothing at all is accepted for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("drum_hit_to_midi_note regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request, idling first at random; leave valid high on return so
   // that a following request goes straight out.
   task send_request(input logic [SMP_W-1:0] smp,
                     input logic [dhmn_pkg::ELAPSED_W-1:0] el);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= smp;
      req_elapsed_ms <= el;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(smp, el);
   endtask

   // Drop valid and hold until every owed message has come out
   task pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Drain, then let a silent request (one that owes nothing) finish too
   task quiesce();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task csr_write(input logic [dhmn_pkg::CSR_INDEX_W-1:0] idx,
                  input logic [dhmn_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task program_registers(input logic [dhmn_pkg::CSR_DATA_W-1:0] thr,
                          input logic [dhmn_pkg::CSR_DATA_W-1:0] nt,
                          input logic [dhmn_pkg::CSR_DATA_W-1:0] sens,
                          input logic [dhmn_pkg::CSR_DATA_W-1:0] cap,
                          input logic [dhmn_pkg::CSR_DATA_W-1:0] len,
                          input bit with_unused);
      csr_write(dhmn_pkg::CSR_THRESHOLD, thr);
      csr_write(dhmn_pkg::CSR_NOTE_NUMBER, nt);
      csr_write(dhmn_pkg::CSR_SENSITIVITY, sens);
      csr_write(dhmn_pkg::CSR_CAPTURE, cap);
      csr_write(dhmn_pkg::CSR_NOTE_LENGTH, len);
      if (with_unused) begin
         csr_write(CSR_UNUSED_LO, dhmn_pkg::CSR_DATA_W'($urandom));
         csr_write(CSR_UNUSED_HI, dhmn_pkg::CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   task apply_setting(input int kind);
      logic [dhmn_pkg::CSR_DATA_W-1:0] thr_d;
      logic [dhmn_pkg::CSR_DATA_W-1:0] note_d;
      logic [dhmn_pkg::CSR_DATA_W-1:0] sens_d;
      logic [dhmn_pkg::CSR_DATA_W-1:0] cap_d;
      logic [dhmn_pkg::CSR_DATA_W-1:0] len_d;
      int pick;
      case (kind)
         SET_TYPICAL: begin
            thr_d  = dhmn_pkg::CSR_DATA_W'($urandom_range(1022, 0));
            note_d = dhmn_pkg::CSR_DATA_W'($urandom_range(127, 0));
            sens_d = dhmn_pkg::CSR_DATA_W'($urandom_range(10, 1));
            cap_d  = dhmn_pkg::CSR_DATA_W'($urandom_range(20, 0));
            len_d  = dhmn_pkg::CSR_DATA_W'($urandom_range(200, 0));
         end
         SET_LOW_EDGE: begin
            thr_d  = '0;
            note_d = '0;
            sens_d = dhmn_pkg::CSR_DATA_W'(1);
            cap_d  = '0;
            len_d  = '0;
         end
         SET_HIGH_END: begin
            thr_d  = dhmn_pkg::CSR_DATA_W'(1022);
            note_d = dhmn_pkg::CSR_DATA_W'(127);
            sens_d = dhmn_pkg::CSR_DATA_W'(10);
            cap_d  = dhmn_pkg::CSR_DATA_W'(1000);
            len_d  = dhmn_pkg::CSR_DATA_W'(10000);
         end
         default: begin
            // Out-of-range values, with junk in the bits above each register
            pick   = $urandom_range(5, 0);
            thr_d  = dhmn_pkg::CSR_DATA_W'($urandom);
            note_d = dhmn_pkg::CSR_DATA_W'($urandom);
            sens_d = {10'($urandom), (pick == 0) ? 4'd0 : 4'(10 + pick)};
            cap_d  = {4'($urandom), 10'h3FF};
            len_d  = '1;
         end
      endcase
      quiesce();
      program_registers(thr_d, note_d, sens_d, cap_d, len_d, kind == SET_BEYOND);
   endtask

   initial begin
      int                             phase_kinds [NUM_PHASES];
      int                             regime;
      int                             ph;
      int                             k;
      bit                             long_wait;
      logic [SMP_W-1:0]               smp;
      logic [dhmn_pkg::ELAPSED_W-1:0] el;

      phase_kinds = '{SET_TYPICAL, SET_LOW_EDGE, SET_TYPICAL, SET_HIGH_END,
                      SET_TYPICAL, SET_BEYOND};
      tracker = new();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Default registers: quiet sample, sample at threshold (no hit), then a
      // full hit with the peak at full scale and timers landing exactly on limits.
      send_request(10'd0, 8'd0);
      send_request(10'd50, 8'd255);
      send_request(10'd51, 8'd0);
      send_request(10'd1023, 8'd1);
      send_request(10'd0, 8'd2);
      send_request(10'd700, 8'd0);
      send_request(10'd0, 8'd40);
      send_request(10'd0, 8'd7);
      send_request(10'd1023, 8'd255);

      // Threshold at full scale: nothing can trigger. Unused indexes must do nothing.
      quiesce();
      program_registers(14'd1023, 14'd127, 14'd0, 14'd0, 14'd0, 1'b1);
      send_request(10'd1023, 8'd255);

      // Threshold one below full scale, sensitivity past range: velocity saturates
      quiesce();
      program_registers(14'd1022, 14'd0, 14'd15, 14'd0, 14'd0, 1'b0);
      send_request(10'd1023, 8'd0);
      send_request(10'd1023, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);

      // Threshold zero, sensitivity zero: first a peak at threshold (velocity zero),
      // then a full-scale peak with a gain of two thirds
      quiesce();
      program_registers(14'd0, 14'd64, 14'd0, 14'd0, 14'd0, 1'b0);
      send_request(10'd1, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd512, 8'd0);
      send_request(10'd1023, 8'd255);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);
      send_request(10'd0, 8'd0);

      for (regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (ph = 0; ph < NUM_PHASES; ph++) begin
            apply_setting(phase_kinds[ph]);
            // Long receiver hold-off while the sender keeps offering requests
            if (ph == 0 && regime != 1) hold_off_requests++;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
               if (k == ITEMS_PER_PHASE / 2) pause_until_drained();
               if ($urandom_range(99) < 15) begin
                  // noise: anything at all, in any mode
                  smp = SMP_W'($urandom);
                  el  = dhmn_pkg::ELAPSED_W'($urandom);
               end else begin
                  // mostly start hits when idle, and advance time briskly when
                  // windows are long so that hits run to their note-off
                  if (tracker.mode == dhmn_pkg::MODE_IDLE && tracker.threshold < FULL_SCALE &&
                      $urandom_range(9) < 7)
                     smp = SMP_W'($urandom_range(FULL_SCALE, int'(tracker.threshold) + 1));
                  else if (tracker.mode == dhmn_pkg::MODE_IDLE)
                     smp = SMP_W'($urandom_range(int'(tracker.threshold), 0));
                  else
                     smp = SMP_W'($urandom);
                  long_wait = (tracker.mode == dhmn_pkg::MODE_COLLECT &&
                               tracker.capture_ms > 200) ||
                              (tracker.mode == dhmn_pkg::MODE_HOLD &&
                               tracker.note_length_ms > 1000);
                  if (long_wait)
                     el = dhmn_pkg::ELAPSED_W'($urandom_range(255, 192));
                  else if ($urandom_range(3) == 0)
                     el = dhmn_pkg::ELAPSED_W'($urandom_range(3, 0));
                  else
                     el = dhmn_pkg::ELAPSED_W'($urandom);
               end
               send_request(smp, el);
            end
         end
      end

      quiesce();
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("drum_hit_to_midi_note regression: pass");
      else
         $display("drum_hit_to_midi_note regression: fail");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dhmn_pkg.sv
hw/rtl/dhmn_ctrl.sv
hw/rtl/dhmn_datapath.sv
hw/rtl/drum_hit_to_midi_note.sv
tb/drum_hit_to_midi_note_test.sv
